FILE: rtl/core/lruexp_pkg.sv
// Shared types and codes for the LRU table with expiry.
// Holds field widths, operation and status codes, cell command and flag types and sequencer states.
// Depends on nothing; lruexp_cell and the top-level core import it.
package lruexp_pkg;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 64;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int USED_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_HIT         = 3'd0,
        STS_MISS        = 3'd1,
        STS_REMOVED     = 3'd2,
        STS_REFRESHED   = 3'd3,
        STS_INSERTED    = 3'd4,
        STS_EVICT_STALE = 3'd5,
        STS_EVICT_LRU   = 3'd6,
        STS_NOT_FOUND   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_FRONT  = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      wr_key;
        logic      wr_exp;
    } cell_cmd_t;

    typedef struct packed {
        logic match;
        logic stale;
        logic free;
        logic lru;
    } cell_flags_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_EVAL  = 2'd1,
        FSM_APPLY = 2'd2
    } fsm_state_t;

endpackage

FILE: rtl/core/lruexp_cell.sv
// One table entry: key, expiry, recency rank and valid bit.
// Registers its compare flags in the evaluate cycle and applies the broadcast
// command in the update cycle. Depends on lruexp_pkg.
module lruexp_cell #(
    parameter int CAPACITY = 16,
    parameter int RANK_W   = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             eval_en,
    input  logic                             sel,
    input  logic [lruexp_pkg::KEY_W-1:0]     req_key,
    input  logic [lruexp_pkg::TIME_W-1:0]    req_now,
    input  logic [lruexp_pkg::TIME_W-1:0]    req_exp,
    input  lruexp_pkg::cell_cmd_t            cmd,
    input  logic [RANK_W-1:0]                old_rank,
    output lruexp_pkg::cell_flags_t          flags,
    output logic [RANK_W-1:0]                rank
);
    import lruexp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [TIME_W-1:0] exp_reg;
    logic [TIME_W-1:0] exp_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    cell_flags_t       flags_reg;
    cell_flags_t       flags_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        exp_next   = exp_reg;
        rank_next  = rank_reg;
        case (cmd.kind)
            CMD_FRONT:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    rank_next  = RANK_W'(1);
                    if (cmd.wr_key)
                    begin
                        key_next = req_key;
                    end
                    if (cmd.wr_exp)
                    begin
                        exp_next = req_exp;
                    end
                end
                else if (valid_reg && (rank_reg < old_rank))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                end
                else if (valid_reg && (rank_reg > old_rank))
                begin
                    rank_next = rank_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        flags_next.match = valid_reg && (key_reg == req_key);
        flags_next.stale = req_now > exp_reg;
        flags_next.free  = !valid_reg;
        flags_next.lru   = valid_reg && (rank_reg == RANK_W'(CAPACITY));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (eval_en)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        exp_reg  <= exp_next;
        rank_reg <= rank_next;
    end

    assign flags = flags_reg;
    assign rank  = rank_reg;

endmodule

FILE: rtl/core/lruexp_pick.sv
// First-set selector along the row of cells.
// Each position passes a "taken" bit to its right neighbor. Depends on nothing.
module lruexp_pick #(
    parameter int N = 16
) (
    input  logic [N-1:0] req,
    output logic [N-1:0] first,
    output logic         any
);
    logic [N:0] taken;

    always_comb
    begin
        taken[0] = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            first[i]     = req[i] && !taken[i];
            taken[i + 1] = taken[i] || req[i];
        end
    end

    assign any = taken[N];

endmodule

FILE: rtl/core/lru_cache_with_expiry_core.sv
// Top level of the LRU table with expiry: request register, sequencer,
// row of entry cells and result register.
// Depends on lruexp_pkg, lruexp_cell and lruexp_pick.
//
// In the evaluate state every cell compares its key and expiry with the
// request and registers the result; in the update state the row's
// first-free and first-stale chains pick a slot, all cells update their ranks
// at once and the result is loaded into the output register. A new item is
// accepted in the update cycle of the one before, so the block takes the next
// item before the last is through while results are taken. A held result
// stalls the update cycle of the next item. Slot contents beyond the key and
// expiry live outside the block, addressed by slot_index.
module lru_cache_with_expiry_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [lruexp_pkg::OP_W-1:0]           operation,
    input  logic [lruexp_pkg::KEY_W-1:0]          lookup_key,
    input  logic [lruexp_pkg::TIME_W-1:0]         time_now,
    input  logic [lruexp_pkg::TIME_W-1:0]         expires_at,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [lruexp_pkg::STATUS_W-1:0]       status,
    output logic [lruexp_pkg::SLOT_OUT_W-1:0]     slot_index,
    output logic [lruexp_pkg::USED_OUT_W-1:0]     entries_used
);
    import lruexp_pkg::*;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = $clog2(CAPACITY + 1);
    localparam int OCC_W  = $clog2(CAPACITY + 1);

    fsm_state_t        state_reg;
    fsm_state_t        state_next;
    logic              in_accept;
    logic              apply_fire;
    logic              eval_en;

    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] exp_reg;

    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [USED_OUT_W-1:0] used_reg;

    cell_flags_t       flags_v [CAPACITY];
    logic [RANK_W-1:0] rank_v  [CAPACITY];
    logic [CAPACITY-1:0] match_v;
    logic [CAPACITY-1:0] stale_v;
    logic [CAPACITY-1:0] free_v;
    logic [CAPACITY-1:0] lru_v;
    logic [CAPACITY-1:0] free_first;
    logic [CAPACITY-1:0] stale_first;
    logic                any_free;
    logic                any_stale;
    logic                any_match;
    logic                match_stale;

    logic [CAPACITY-1:0] sel;
    cell_cmd_t           cmd;
    cell_cmd_t           cell_cmd;
    logic                insert;
    logic                occ_inc;
    logic                occ_dec;
    status_t             sts;
    logic [RANK_W-1:0]   old_rank;
    logic [SLOT_W-1:0]   slot_idx;
    logic [31:0]         slot_ext;
    logic [31:0]         occ_ext;

    assign apply_fire = (state_reg == FSM_APPLY) && (!out_valid_reg || !out_stall);
    assign in_stall   = !((state_reg == FSM_IDLE) || apply_fire);
    assign in_accept  = in_valid && !in_stall;
    assign eval_en    = (state_reg == FSM_EVAL);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = FSM_EVAL;
                end
            end
            FSM_EVAL:
            begin
                state_next = FSM_APPLY;
            end
            FSM_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = in_accept ? FSM_EVAL : FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= operation;
            key_reg <= lookup_key;
            now_reg <= time_now;
            exp_reg <= expires_at;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        lruexp_cell #(
            .CAPACITY (CAPACITY),
            .RANK_W   (RANK_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .eval_en  (eval_en),
            .sel      (sel[g]),
            .req_key  (key_reg),
            .req_now  (now_reg),
            .req_exp  (exp_reg),
            .cmd      (cell_cmd),
            .old_rank (old_rank),
            .flags    (flags_v[g]),
            .rank     (rank_v[g])
        );
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_v[i] = flags_v[i].match;
            stale_v[i] = flags_v[i].stale;
            free_v[i]  = flags_v[i].free;
            lru_v[i]   = flags_v[i].lru;
        end
    end

    lruexp_pick #(.N(CAPACITY)) u_pick_free (
        .req   (free_v),
        .first (free_first),
        .any   (any_free)
    );

    lruexp_pick #(.N(CAPACITY)) u_pick_stale (
        .req   (stale_v),
        .first (stale_first),
        .any   (any_stale)
    );

    // Keys are unique among valid entries, so at most one cell matches.
    assign any_match   = |match_v;
    assign match_stale = |(match_v & stale_v);

    always_comb
    begin
        sel        = '0;
        cmd.kind   = CMD_NONE;
        cmd.wr_key = 1'b0;
        cmd.wr_exp = 1'b0;
        insert     = 1'b0;
        occ_inc    = 1'b0;
        occ_dec    = 1'b0;
        sts        = STS_MISS;
        case (op_t'(op_reg))
            OP_GET:
            begin
                if (any_match)
                begin
                    sel = match_v;
                    if (match_stale)
                    begin
                        cmd.kind = CMD_DELETE;
                        occ_dec  = 1'b1;
                        sts      = STS_REMOVED;
                    end
                    else
                    begin
                        cmd.kind = CMD_FRONT;
                        sts      = STS_HIT;
                    end
                end
            end
            OP_PUT:
            begin
                cmd.kind   = CMD_FRONT;
                cmd.wr_exp = 1'b1;
                if (any_match)
                begin
                    sel = match_v;
                    sts = STS_REFRESHED;
                end
                else if (any_free)
                begin
                    sel        = free_first;
                    cmd.wr_key = 1'b1;
                    insert     = 1'b1;
                    occ_inc    = 1'b1;
                    sts        = STS_INSERTED;
                end
                else if (any_stale)
                begin
                    sel        = stale_first;
                    cmd.wr_key = 1'b1;
                    sts        = STS_EVICT_STALE;
                end
                else
                begin
                    sel        = lru_v;
                    cmd.wr_key = 1'b1;
                    sts        = STS_EVICT_LRU;
                end
            end
            OP_REMOVE:
            begin
                if (any_match)
                begin
                    sel      = match_v;
                    cmd.kind = CMD_DELETE;
                    occ_dec  = 1'b1;
                    sts      = STS_REMOVED;
                end
                else
                begin
                    sts = STS_NOT_FOUND;
                end
            end
            default:
            begin
                sts = STS_MISS;
            end
        endcase
    end

    always_comb
    begin
        old_rank = '0;
        slot_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel[i])
            begin
                old_rank = old_rank | rank_v[i];
                slot_idx = slot_idx | SLOT_W'(i);
            end
        end
        // A fresh insert ages every valid entry, all of which rank below CAPACITY.
        if (insert)
        begin
            old_rank = RANK_W'(CAPACITY);
        end
    end

    always_comb
    begin
        cell_cmd = cmd;
        if (!apply_fire)
        begin
            cell_cmd.kind = CMD_NONE;
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (occ_inc)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (occ_dec)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    assign slot_ext = 32'(slot_idx);
    assign occ_ext  = 32'(occ_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (apply_fire)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            status_reg <= sts;
            slot_reg   <= slot_ext[SLOT_OUT_W-1:0];
            used_reg   <= occ_ext[USED_OUT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot_index   = slot_reg;
    assign entries_used = used_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_APPLY) |-> $onehot0(match_v))
        else $error("key present in more than one entry");

    a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == FSM_APPLY) && (op_t'(op_reg) == OP_PUT) && !any_match && !any_free)
        |-> $onehot(lru_v))
        else $error("full table without a single oldest entry");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |=> out_valid_reg)
        else $error("update cycle left no result");

endmodule

FILE: sim/lru_cache_with_expiry_core_tb.sv
// Self-checking testbench for lru_cache_with_expiry_core, the keyed LRU table with expiry.
// Needs lruexp_pkg and the core RTL; it predicts every result and checks it against the block.
`timescale 1ns / 100ps

module lru_cache_with_expiry_core_tb;

    import lruexp_pkg::*;

    localparam int CAPACITY = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int TAIL_ITEMS = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        status_t                 status;
        logic [SLOT_OUT_W-1:0]   slot;
        logic [USED_OUT_W-1:0]   used;
    } lru_reply_t;

    class lru_table_tracker;
        localparam int SLOTS = CAPACITY;
        logic [KEY_W-1:0]  key_of [SLOTS];
        logic [TIME_W-1:0] expiry_of [SLOTS];
        int unsigned       rank_of [SLOTS];
        bit                live [SLOTS];
        int unsigned       live_count;
        int unsigned       errors;
        lru_reply_t        expected_results [$];

        function new();
            int j;
            for (j = 0; j < SLOTS; j++)
            begin
                live[j] = 1'b0;
            end
            live_count = 0;
            errors = 0;
        endfunction

        function int find_slot(logic [KEY_W-1:0] key);
            int j;
            for (j = 0; j < SLOTS; j++)
            begin
                if (live[j] && key_of[j] == key)
                begin
                    return j;
                end
            end
            return -1;
        endfunction

        function void promote(int s, int unsigned old_rank);
            int j;
            for (j = 0; j < SLOTS; j++)
            begin
                if (j != s && live[j] && rank_of[j] < old_rank)
                begin
                    rank_of[j]++;
                end
            end
            rank_of[s] = 1;
        endfunction

        function void drop(int s);
            int j;
            live[s] = 1'b0;
            for (j = 0; j < SLOTS; j++)
            begin
                if (live[j] && rank_of[j] > rank_of[s])
                begin
                    rank_of[j]--;
                end
            end
            live_count--;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [TIME_W-1:0] now, logic [TIME_W-1:0] expiry);
            lru_reply_t r;
            int hit;
            int pick;
            int j;
            r.status = STS_MISS;
            r.slot = '0;
            hit = find_slot(key);
            case (op)
                OP_GET:
                begin
                    if (hit >= 0)
                    begin
                        r.slot = SLOT_OUT_W'(hit);
                        if (now > expiry_of[hit])
                        begin
                            drop(hit);
                            r.status = STS_REMOVED;
                        end
                        else
                        begin
                            promote(hit, rank_of[hit]);
                            r.status = STS_HIT;
                        end
                    end
                end
                OP_PUT:
                begin
                    if (hit >= 0)
                    begin
                        expiry_of[hit] = expiry;
                        promote(hit, rank_of[hit]);
                        r.status = STS_REFRESHED;
                        r.slot = SLOT_OUT_W'(hit);
                    end
                    else
                    begin
                        pick = -1;
                        for (j = 0; j < SLOTS; j++)
                        begin
                            if (!live[j] && pick < 0)
                            begin
                                pick = j;
                            end
                        end
                        if (pick >= 0)
                        begin
                            for (j = 0; j < SLOTS; j++)
                            begin
                                if (j != pick && live[j])
                                begin
                                    rank_of[j]++;
                                end
                            end
                            live[pick] = 1'b1;
                            rank_of[pick] = 1;
                            live_count++;
                            r.status = STS_INSERTED;
                        end
                        else
                        begin
                            for (j = 0; j < SLOTS; j++)
                            begin
                                if (pick < 0 && now > expiry_of[j])
                                begin
                                    pick = j;
                                end
                            end
                            if (pick >= 0)
                            begin
                                r.status = STS_EVICT_STALE;
                            end
                            else
                            begin
                                pick = 0;
                                for (j = 1; j < SLOTS; j++)
                                begin
                                    if (rank_of[j] > rank_of[pick])
                                    begin
                                        pick = j;
                                    end
                                end
                                r.status = STS_EVICT_LRU;
                            end
                            promote(pick, rank_of[pick]);
                        end
                        key_of[pick] = key;
                        expiry_of[pick] = expiry;
                        r.slot = SLOT_OUT_W'(pick);
                    end
                end
                OP_REMOVE:
                begin
                    if (hit >= 0)
                    begin
                        drop(hit);
                        r.status = STS_REMOVED;
                        r.slot = SLOT_OUT_W'(hit);
                    end
                    else
                    begin
                        r.status = STS_NOT_FOUND;
                    end
                end
                default:
                begin
                end
            endcase
            r.used = USED_OUT_W'(live_count);
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_OUT_W-1:0] sl,
                                   logic [USED_OUT_W-1:0] nu);
            lru_reply_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, status %0d slot %0d used %0d",
                         $time, st, sl, nu);
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
            if (sl !== want.slot)
            begin
                errors++;
                $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, sl);
            end
            if (nu !== want.used)
            begin
                errors++;
                $display("%0t: entries_used expected %0d actual %0d", $time, want.used, nu);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation = OP_GET;
    logic [KEY_W-1:0]      lookup_key = '0;
    logic [TIME_W-1:0]     time_now = '0;
    logic [TIME_W-1:0]     expires_at = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [USED_OUT_W-1:0] entries_used;

    bit tail_quiet = 1'b0;
    int hold_asks = 0;

    lru_table_tracker board = new();

    always #5 clk = ~clk;

    lru_cache_with_expiry_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .lookup_key(lookup_key),
        .time_now(time_now),
        .expires_at(expires_at),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .slot_index(slot_index),
        .entries_used(entries_used)
    );

    task automatic offer(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] expiry,
                         input bit may_idle);
        bit took;
        took = 1'b0;
        operation <= op;
        lookup_key <= key;
        time_now <= now;
        expires_at <= expiry;
        in_valid <= 1'b1;
        while (!took)
        begin
            @(negedge clk);
            if (!in_stall)
            begin
                took = 1'b1;
                board.note_request(op, key, now, expiry);
            end
            @(posedge clk);
        end
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        while (board.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : request_side
        logic [KEY_W-1:0]  key_pool [32];
        logic [KEY_W-1:0]  fill_keys [CAPACITY];
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] cur_time;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] expiry;
        logic [OP_W-1:0]   op;
        int                span;
        int                roll;
        int                n;
        bit                may_idle;
        for (n = 0; n < 32; n++)
        begin
            key_pool[n] = {$urandom, $urandom};
        end
        for (n = 0; n < CAPACITY; n++)
        begin
            fill_keys[n] = {$urandom, $urandom};
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        offer(OP_GET, '0, '0, '0, 1'b1);
        offer(OP_REMOVE, KEY_ONES, TIME_MAX, TIME_MAX, 1'b1);
        offer(OP_UNUSED, KEY_ONES, '0, TIME_MAX, 1'b1);
        offer(OP_PUT, '0, '0, TIME_MAX, 1'b1);
        offer(OP_PUT, KEY_ONES, '0, '0, 1'b1);
        offer(OP_GET, KEY_ONES, '0, '0, 1'b1);
        offer(OP_GET, KEY_ONES, 32'd1, '0, 1'b1);
        offer(OP_GET, '0, TIME_MAX, '0, 1'b1);
        offer(OP_PUT, '0, 32'd100, 32'd5, 1'b1);
        for (n = 1; n < CAPACITY; n++)
        begin
            offer(OP_PUT, fill_keys[n], 32'd100, 32'd1000, 1'b1);
        end
        offer(OP_PUT, fill_keys[0], 32'd500, 32'd1000, 1'b1);
        offer(OP_PUT, KEY_ONES, 32'd500, 32'd1000, 1'b1);
        offer(OP_REMOVE, fill_keys[5], 32'd500, '0, 1'b1);
        wait_for_results();

        cur_time = $urandom;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            span = ((n / 200) % 2 == 0) ? 30 : 10;
            if (n == 300)
            begin
                hold_asks++;
            end
            if (n == 700)
            begin
                wait_for_results();
            end
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
            begin
                tail_quiet = 1'b1;
            end
            may_idle = !(n >= 300 && n < 340) && !tail_quiet;
            if ($urandom_range(0, 49) == 0)
            begin
                key_pool[$urandom_range(0, 31)] = {$urandom, $urandom};
            end
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                op = OP_PUT;
            end
            else if (roll < 85)
            begin
                op = OP_GET;
            end
            else if (roll < 99)
            begin
                op = OP_REMOVE;
            end
            else
            begin
                op = OP_UNUSED;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                key = {$urandom, $urandom};
            end
            else
            begin
                key = key_pool[$urandom_range(0, span - 1)];
            end
            cur_time = cur_time + $urandom_range(0, 3);
            now = ($urandom_range(0, 59) == 0) ? $urandom : cur_time;
            roll = $urandom_range(0, 9);
            if (roll == 0)
            begin
                expiry = $urandom;
            end
            else if (roll == 1)
            begin
                expiry = cur_time - $urandom_range(1, 20);
            end
            else
            begin
                expiry = cur_time + $urandom_range(0, 80);
            end
            offer(op, key, now, expiry, may_idle);
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin : result_side
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left = 0;
        hold_left = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (out_valid && !out_stall)
            begin
                board.check_result(status, slot_index, entries_used);
            end
            @(posedge clk);
            if (hold_asks != holds_done && hold_left == 0)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (tail_quiet)
            begin
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/lruexp_pkg.sv
rtl/core/lruexp_cell.sv
rtl/core/lruexp_pick.sv
rtl/core/lru_cache_with_expiry_core.sv
sim/lru_cache_with_expiry_core_tb.sv
